[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk_i and are disabled while rst_ni is low.
`define ICR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("collision response assertion failed");

`define ICR_NEVER(lbl, cond) `ICR_ASSERT(lbl, !(cond))

`endif

[sv/icr_pkg.sv]
package icr_pkg;

  localparam int FRAC_BITS = 16;

  localparam int VEL_W      = 32;
  localparam int INV_W      = 31;
  localparam int BNC_W      = 17;
  localparam int NRM_W      = 18;
  localparam int DEP_W      = 31;
  localparam int PCT_W      = 17;
  localparam int SLOP_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam int DV_W   = VEL_W + 1;
  localparam int PROD_W = DV_W + NRM_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int SUM_W  = INV_W + 1;
  localparam int NEGV_W = DOT_W - FRAC_BITS;
  localparam int ONEE_W = ((FRAC_BITS > BNC_W) ? FRAC_BITS : BNC_W) + 1;
  localparam int NUM_W  = NEGV_W + ONEE_W;
  localparam int N2_W   = DEP_W + PCT_W;
  localparam int REM_W  = SUM_W;

  localparam int JL      = NUM_W / 2;
  localparam int JH      = NUM_W - JL;
  localparam int T_RAW_W = NUM_W + INV_W;
  localparam int MAG_W   = VEL_W + 2;
  localparam int T_W     = MAG_W + 2 * FRAC_BITS;
  localparam int ABS_W   = NRM_W;
  localparam int TL      = T_W / 2;
  localparam int TH      = T_W - TL;
  localparam int P_W     = T_W + ABS_W;
  localparam int ACC_W   = MAG_W + 2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  localparam int OCC_W      = 3;
  localparam int BUSY_W     = FIFO_CW + 1;

  localparam logic [PCT_W-1:0]  PCT_RESET  = PCT_W'(((9 << FRAC_BITS) + 5) / 10);
  localparam logic [SLOP_W-1:0] SLOP_RESET = SLOP_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [ONEE_W-1:0] ONE_E      = ONEE_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCT  = 2'd0,
    CFG_SLOP = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] avx;
    logic signed [VEL_W-1:0] avy;
    logic signed [VEL_W-1:0] bvx;
    logic signed [VEL_W-1:0] bvy;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic [INV_W-1:0]        inva;
    logic [INV_W-1:0]        invb;
    logic [SUM_W-1:0]        sum;
    logic                    sep;
    logic                    imm;
  } ctx_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [NUM_W-1:0] n1;
    logic [NUM_W-1:0] n2;
  } job_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic [3:0][VEL_W-1:0] vel;
    logic [3:0][VEL_W-1:0] shift;
    logic                  sep;
    logic                  imm;
  } res_t;

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[VEL_W-1:0];
    end else if (x < lo) begin
      return lo[VEL_W-1:0];
    end
    return x[VEL_W-1:0];
  endfunction

endpackage

[sv/icr_front.sv]
module icr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 acc_i,
  input  logic signed [icr_pkg::VEL_W-1:0]     a_vel_x_i,
  input  logic signed [icr_pkg::VEL_W-1:0]     a_vel_y_i,
  input  logic signed [icr_pkg::VEL_W-1:0]     b_vel_x_i,
  input  logic signed [icr_pkg::VEL_W-1:0]     b_vel_y_i,
  input  logic [icr_pkg::INV_W-1:0]            a_inv_mass_i,
  input  logic [icr_pkg::INV_W-1:0]            b_inv_mass_i,
  input  logic [icr_pkg::BNC_W-1:0]            a_bounce_i,
  input  logic [icr_pkg::BNC_W-1:0]            b_bounce_i,
  input  logic signed [icr_pkg::NRM_W-1:0]     normal_x_i,
  input  logic signed [icr_pkg::NRM_W-1:0]     normal_y_i,
  input  logic [icr_pkg::DEP_W-1:0]            depth_i,
  input  logic                                 cfg_valid_i,
  input  logic [icr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [icr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 push_o,
  output icr_pkg::job_t                        job_o,
  output logic [icr_pkg::OCC_W-1:0]            occ_o
);
  import icr_pkg::*;

  typedef struct packed {
    logic signed [VEL_W-1:0] avx;
    logic signed [VEL_W-1:0] avy;
    logic signed [VEL_W-1:0] bvx;
    logic signed [VEL_W-1:0] bvy;
    logic signed [DV_W-1:0]  dvx;
    logic signed [DV_W-1:0]  dvy;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic [INV_W-1:0]        inva;
    logic [INV_W-1:0]        invb;
    logic [BNC_W-1:0]        e;
    logic [DEP_W-1:0]        d;
  } f1_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]  avx;
    logic signed [VEL_W-1:0]  avy;
    logic signed [VEL_W-1:0]  bvx;
    logic signed [VEL_W-1:0]  bvy;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic [INV_W-1:0]         inva;
    logic [INV_W-1:0]         invb;
    logic [SUM_W-1:0]         sum;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic [BNC_W-1:0]         e;
    logic [N2_W-1:0]          n2;
  } f2_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [BNC_W-1:0]  e;
    logic [NEGV_W-1:0] negv;
    logic [N2_W-1:0]   n2;
  } f3_t;

  logic [PCT_W-1:0]  pct_q;
  logic [SLOP_W-1:0] slop_q;
  logic              v1_q, v2_q, v3_q, v4_q;
  f1_t               f1_d, f1_q;
  f2_t               f2_d, f2_q;
  f3_t               f3_d, f3_q;
  job_t              job_d, job_q;
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q  <= PCT_RESET;
      slop_q <= SLOP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_PCT:  pct_q  <= cfg_data_i[PCT_W-1:0];
        CFG_SLOP: slop_q <= cfg_data_i[SLOP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    f1_d.avx  = a_vel_x_i;
    f1_d.avy  = a_vel_y_i;
    f1_d.bvx  = b_vel_x_i;
    f1_d.bvy  = b_vel_y_i;
    f1_d.dvx  = {b_vel_x_i[VEL_W-1], b_vel_x_i} - {a_vel_x_i[VEL_W-1], a_vel_x_i};
    f1_d.dvy  = {b_vel_y_i[VEL_W-1], b_vel_y_i} - {a_vel_y_i[VEL_W-1], a_vel_y_i};
    f1_d.nx   = normal_x_i;
    f1_d.ny   = normal_y_i;
    f1_d.inva = a_inv_mass_i;
    f1_d.invb = b_inv_mass_i;
    f1_d.e    = (a_bounce_i > b_bounce_i) ? a_bounce_i : b_bounce_i;
    f1_d.d    = (depth_i > slop_q) ? depth_i - slop_q : '0;
  end

  always_comb begin
    f2_d.avx  = f1_q.avx;
    f2_d.avy  = f1_q.avy;
    f2_d.bvx  = f1_q.bvx;
    f2_d.bvy  = f1_q.bvy;
    f2_d.nx   = f1_q.nx;
    f2_d.ny   = f1_q.ny;
    f2_d.inva = f1_q.inva;
    f2_d.invb = f1_q.invb;
    f2_d.sum  = SUM_W'(f1_q.inva) + SUM_W'(f1_q.invb);
    f2_d.px   = f1_q.dvx * f1_q.nx;
    f2_d.py   = f1_q.dvy * f1_q.ny;
    f2_d.e    = f1_q.e;
    f2_d.n2   = N2_W'(f1_q.d) * N2_W'(pct_q);
  end

  always_comb begin
    dot           = f2_q.px + f2_q.py;
    rnd           = -dot + DOT_W'((1 << FRAC_BITS) - 1);
    f3_d.ctx.avx  = f2_q.avx;
    f3_d.ctx.avy  = f2_q.avy;
    f3_d.ctx.bvx  = f2_q.bvx;
    f3_d.ctx.bvy  = f2_q.bvy;
    f3_d.ctx.nx   = f2_q.nx;
    f3_d.ctx.ny   = f2_q.ny;
    f3_d.ctx.inva = f2_q.inva;
    f3_d.ctx.invb = f2_q.invb;
    f3_d.ctx.sum  = f2_q.sum;
    f3_d.ctx.sep  = dot > 0;
    f3_d.ctx.imm  = f2_q.sum == '0;
    f3_d.e        = f2_q.e;
    f3_d.negv     = f3_d.ctx.sep ? '0 : rnd[DOT_W-1:FRAC_BITS];
    f3_d.n2       = f2_q.n2;
  end

  always_comb begin
    job_d.ctx = f3_q.ctx;
    job_d.n1  = NUM_W'(ONE_E + ONEE_W'(f3_q.e)) * NUM_W'(f3_q.negv);
    job_d.n2  = NUM_W'(f3_q.n2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= acc_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      f1_q <= f1_d;
    end
    f2_q  <= f2_d;
    f3_q  <= f3_d;
    job_q <= job_d;
  end

  assign push_o = v4_q;
  assign job_o  = job_q;
  assign occ_o  = OCC_W'(v1_q) + OCC_W'(v2_q) + OCC_W'(v3_q) + OCC_W'(v4_q);

endmodule

[sv/icr_fifo.sv]
module icr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  icr_pkg::job_t       data_i,
  input  logic                pop_i,
  output icr_pkg::job_t       data_o,
  output logic                valid_o,
  output icr_pkg::fifo_stat_t stat_o
);
  import icr_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  job_t               data_q;
  logic               valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q   <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
      valid_q <= pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
    if (pop_i) begin
      data_q <= mem_q[rd_q];
    end
  end

  assign data_o       = data_q;
  assign valid_o      = valid_q;
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign stat_o.count = cnt_q;

endmodule

[sv/icr_div.sv]
module icr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  icr_pkg::job_t              job_i,
  output logic                       valid_o,
  output icr_pkg::ctx_t              ctx_o,
  output logic [icr_pkg::NUM_W-1:0]  jq_o,
  output logic [icr_pkg::NUM_W-1:0]  q_o
);
  import icr_pkg::*;

  logic             vld_q [NUM_W];
  ctx_t             ctx_q [NUM_W];
  logic [REM_W-1:0] r1_q  [NUM_W];
  logic [REM_W-1:0] r2_q  [NUM_W];
  logic [NUM_W-1:0] a1_q  [NUM_W];
  logic [NUM_W-1:0] a2_q  [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             sv;
    ctx_t             sc;
    logic [REM_W-1:0] sr1, sr2;
    logic [NUM_W-1:0] sa1, sa2;
    logic [REM_W:0]   t1, t2;
    logic             ge1, ge2;

    if (s == 0) begin : g_first
      assign sv  = valid_i;
      assign sc  = job_i.ctx;
      assign sr1 = '0;
      assign sr2 = '0;
      assign sa1 = job_i.n1;
      assign sa2 = job_i.n2;
    end else begin : g_next
      assign sv  = vld_q[s-1];
      assign sc  = ctx_q[s-1];
      assign sr1 = r1_q[s-1];
      assign sr2 = r2_q[s-1];
      assign sa1 = a1_q[s-1];
      assign sa2 = a2_q[s-1];
    end

    assign t1  = {sr1, sa1[NUM_W-1]};
    assign t2  = {sr2, sa2[NUM_W-1]};
    assign ge1 = t1 >= {1'b0, sc.sum};
    assign ge2 = t2 >= {1'b0, sc.sum};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      ctx_q[s] <= sc;
      r1_q[s]  <= ge1 ? REM_W'(t1 - {1'b0, sc.sum}) : t1[REM_W-1:0];
      r2_q[s]  <= ge2 ? REM_W'(t2 - {1'b0, sc.sum}) : t2[REM_W-1:0];
      a1_q[s]  <= {sa1[NUM_W-2:0], ge1};
      a2_q[s]  <= {sa2[NUM_W-2:0], ge2};
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign ctx_o   = ctx_q[NUM_W-1];
  assign jq_o    = a1_q[NUM_W-1];
  assign q_o     = a2_q[NUM_W-1];

endmodule

[sv/icr_scale.sv]
module icr_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  icr_pkg::ctx_t             ctx_i,
  input  logic [icr_pkg::NUM_W-1:0] jq_i,
  input  logic [icr_pkg::NUM_W-1:0] q_i,
  output logic                      valid_o,
  output icr_pkg::res_t             res_o
);
  import icr_pkg::*;

  localparam logic [T_RAW_W-1:0] T_CAP   = T_RAW_W'(1) << (T_W - 1);
  localparam logic [P_W-1:0]     MAG_CAP = P_W'(1) << (MAG_W - 1);

  logic [4:0]             v_q;
  ctx_t                   c1_q, c2_q, c3_q, c4_q;
  logic [JL+INV_W-1:0]    plo_d [4];
  logic [JL+INV_W-1:0]    plo_q [4];
  logic [JH+INV_W-1:0]    phi_d [4];
  logic [JH+INV_W-1:0]    phi_q [4];
  logic [T_W-1:0]         t_d [4];
  logic [T_W-1:0]         t_q [4];
  logic [ABS_W-1:0]       ax_d, ay_d, ax_q, ay_q;
  logic [TL+ABS_W-1:0]    mlo_d [8];
  logic [TL+ABS_W-1:0]    mlo_q [8];
  logic [TH+ABS_W-1:0]    mhi_d [8];
  logic [TH+ABS_W-1:0]    mhi_q [8];
  logic [MAG_W-1:0]       mag_d [8];
  logic [MAG_W-1:0]       mag_q [8];
  res_t                   res_d, res_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [NUM_W-1:0] qv;
      logic [INV_W-1:0] iv;
      qv = k[1] ? q_i : jq_i;
      iv = k[0] ? ctx_i.invb : ctx_i.inva;
      plo_d[k] = (JL+INV_W)'(qv[JL-1:0]) * (JL+INV_W)'(iv);
      phi_d[k] = (JH+INV_W)'(qv[NUM_W-1:JL]) * (JH+INV_W)'(iv);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [T_RAW_W-1:0] raw;
      raw    = (T_RAW_W'(phi_q[k]) << JL) + T_RAW_W'(plo_q[k]);
      t_d[k] = (raw >= T_CAP) ? T_CAP[T_W-1:0] : raw[T_W-1:0];
    end
    ax_d = (c1_q.nx < 0) ? ABS_W'(-c1_q.nx) : ABS_W'(c1_q.nx);
    ay_d = (c1_q.ny < 0) ? ABS_W'(-c1_q.ny) : ABS_W'(c1_q.ny);
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic [T_W-1:0]   tv;
      logic [ABS_W-1:0] av;
      tv = t_q[k[2:1]];
      av = k[0] ? ay_q : ax_q;
      mlo_d[k] = (TL+ABS_W)'(tv[TL-1:0]) * (TL+ABS_W)'(av);
      mhi_d[k] = (TH+ABS_W)'(tv[T_W-1:TL]) * (TH+ABS_W)'(av);
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic [P_W-1:0] p;
      logic [P_W-1:0] sh;
      p        = (P_W'(mhi_q[k]) << TL) + P_W'(mlo_q[k]);
      sh       = p >> (2 * FRAC_BITS);
      mag_d[k] = (sh >= MAG_CAP) ? MAG_CAP[MAG_W-1:0] : sh[MAG_W-1:0];
    end
  end

  always_comb begin
    logic [3:0][VEL_W-1:0] base;
    base = {c4_q.bvy, c4_q.bvx, c4_q.avy, c4_q.avx};
    for (int k = 0; k < 4; k++) begin
      logic                    negn;
      logic                    negd;
      logic signed [ACC_W-1:0] mj;
      logic signed [ACC_W-1:0] mq;
      negn = k[0] ? c4_q.ny[NRM_W-1] : c4_q.nx[NRM_W-1];
      negd = negn ^ ~k[1];
      mj   = ACC_W'(mag_q[k]);
      mq   = ACC_W'(mag_q[4 + k]);
      if (negd) begin
        mj = -mj;
        mq = -mq;
      end
      if (c4_q.imm || c4_q.sep) begin
        res_d.vel[k] = base[k];
      end else begin
        res_d.vel[k] = sat_vel(ACC_W'(signed'(base[k])) + mj);
      end
      res_d.shift[k] = c4_q.imm ? '0 : sat_vel(mq);
    end
    res_d.sep = c4_q.sep;
    res_d.imm = c4_q.imm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= ctx_i;
    c2_q  <= c1_q;
    c3_q  <= c2_q;
    c4_q  <= c3_q;
    plo_q <= plo_d;
    phi_q <= phi_d;
    t_q   <= t_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    mlo_q <= mlo_d;
    mhi_q <= mhi_d;
    mag_q <= mag_d;
    res_q <= res_d;
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule

[sv/impulse_collision_response_2d_top.sv]
// Channel   | Direction | Handshake                 | Word
// contact   | in        | start_i / busy_o          | velocities, inverse masses, bounce, normal, depth
// result    | out       | done_o (one cycle)        | new velocities, shifts, separating, both_immovable
// config    | in        | cfg_valid_i / cfg_ready_o | cfg_idx_i, cfg_data_i
//
// One contact can be taken every cycle; busy_o only rises if the queue between the
// classifier front end and the back end would overflow.
// The quotients come from a bit-per-stage divider in the back end.
// Reset is asynchronous and active low; it restores the default percent and slop.
// The result is shown for exactly one cycle and cannot be held off.
`include "assert_macros.svh"

module impulse_collision_response_2d_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [icr_pkg::VEL_W-1:0]    a_vel_x_i,
  input  logic signed [icr_pkg::VEL_W-1:0]    a_vel_y_i,
  input  logic signed [icr_pkg::VEL_W-1:0]    b_vel_x_i,
  input  logic signed [icr_pkg::VEL_W-1:0]    b_vel_y_i,
  input  logic [icr_pkg::INV_W-1:0]           a_inv_mass_i,
  input  logic [icr_pkg::INV_W-1:0]           b_inv_mass_i,
  input  logic [icr_pkg::BNC_W-1:0]           a_bounce_i,
  input  logic [icr_pkg::BNC_W-1:0]           b_bounce_i,
  input  logic signed [icr_pkg::NRM_W-1:0]    normal_x_i,
  input  logic signed [icr_pkg::NRM_W-1:0]    normal_y_i,
  input  logic [icr_pkg::DEP_W-1:0]           depth_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [icr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [icr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic signed [icr_pkg::VEL_W-1:0]    a_new_vel_x_o,
  output logic signed [icr_pkg::VEL_W-1:0]    a_new_vel_y_o,
  output logic signed [icr_pkg::VEL_W-1:0]    b_new_vel_x_o,
  output logic signed [icr_pkg::VEL_W-1:0]    b_new_vel_y_o,
  output logic signed [icr_pkg::VEL_W-1:0]    a_shift_x_o,
  output logic signed [icr_pkg::VEL_W-1:0]    a_shift_y_o,
  output logic signed [icr_pkg::VEL_W-1:0]    b_shift_x_o,
  output logic signed [icr_pkg::VEL_W-1:0]    b_shift_y_o,
  output logic                                separating_o,
  output logic                                both_immovable_o
);
  import icr_pkg::*;

  logic             acc;
  logic             fifo_push;
  logic             fifo_pop;
  logic             fifo_valid;
  job_t             front_job;
  job_t             fifo_job;
  fifo_stat_t       fstat;
  logic [OCC_W-1:0] front_occ;
  logic             div_valid;
  ctx_t             div_ctx;
  logic [NUM_W-1:0] div_jq, div_q;
  res_t             res;
  logic             shifts_zero;
  logic             shift_x_both;

  assign busy_o      = (BUSY_W'(fstat.count) + BUSY_W'(front_occ)) >= BUSY_W'(FIFO_DEPTH);
  assign acc         = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign fifo_pop    = !fstat.empty;

  icr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .a_vel_x_i    (a_vel_x_i),
    .a_vel_y_i    (a_vel_y_i),
    .b_vel_x_i    (b_vel_x_i),
    .b_vel_y_i    (b_vel_y_i),
    .a_inv_mass_i (a_inv_mass_i),
    .b_inv_mass_i (b_inv_mass_i),
    .a_bounce_i   (a_bounce_i),
    .b_bounce_i   (b_bounce_i),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .depth_i      (depth_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (fifo_push),
    .job_o        (front_job),
    .occ_o        (front_occ)
  );

  icr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_job),
    .pop_i   (fifo_pop),
    .data_o  (fifo_job),
    .valid_o (fifo_valid),
    .stat_o  (fstat)
  );

  icr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .job_i   (fifo_job),
    .valid_o (div_valid),
    .ctx_o   (div_ctx),
    .jq_o    (div_jq),
    .q_o     (div_q)
  );

  icr_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ctx_i   (div_ctx),
    .jq_i    (div_jq),
    .q_i     (div_q),
    .valid_o (done_o),
    .res_o   (res)
  );

  assign a_new_vel_x_o    = res.vel[0];
  assign a_new_vel_y_o    = res.vel[1];
  assign b_new_vel_x_o    = res.vel[2];
  assign b_new_vel_y_o    = res.vel[3];
  assign a_shift_x_o      = res.shift[0];
  assign a_shift_y_o      = res.shift[1];
  assign b_shift_x_o      = res.shift[2];
  assign b_shift_y_o      = res.shift[3];
  assign separating_o     = res.sep;
  assign both_immovable_o = res.imm;

  assign shifts_zero  = (a_shift_x_o == '0) && (a_shift_y_o == '0) &&
                        (b_shift_x_o == '0) && (b_shift_y_o == '0);
  assign shift_x_both = (a_shift_x_o != '0) && (b_shift_x_o != '0);

  `ICR_NEVER(a_fifo_overflow, fifo_push && fstat.full)
  `ICR_ASSERT(a_immovable_no_shift, done_o && both_immovable_o |-> shifts_zero)
  `ICR_ASSERT(a_shift_opposite, done_o && shift_x_both |-> a_shift_x_o[VEL_W-1] != b_shift_x_o[VEL_W-1])

endmodule

[dv/impulse_collision_response_2d_checker.sv]
module impulse_collision_response_2d_checker
  import icr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic signed [VEL_W-1:0] a_vel_x_i,
  input  logic signed [VEL_W-1:0] a_vel_y_i,
  input  logic signed [VEL_W-1:0] b_vel_x_i,
  input  logic signed [VEL_W-1:0] b_vel_y_i,
  input  logic [INV_W-1:0]        a_inv_mass_i,
  input  logic [INV_W-1:0]        b_inv_mass_i,
  input  logic [BNC_W-1:0]        a_bounce_i,
  input  logic [BNC_W-1:0]        b_bounce_i,
  input  logic signed [NRM_W-1:0] normal_x_i,
  input  logic signed [NRM_W-1:0] normal_y_i,
  input  logic [DEP_W-1:0]        depth_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    done_i,
  input  logic [7:0][VEL_W-1:0]   result_i,
  input  logic                    separating_i,
  input  logic                    both_immovable_i,
  output int                      errors_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0][VEL_W-1:0] word;
    logic                  sep;
    logic                  imm;
  } contact_res_t;

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned CAP = 64'd1 << 40;

  logic [PCT_W-1:0]  pct_q;
  logic [SLOP_W-1:0] slop_q;
  contact_res_t      expected_q[$];
  int                errors;
  int                pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint unsigned scale_mag(longint unsigned x, longint unsigned c);
    logic [127:0] p;
    p = ({64'd0, x} * {64'd0, c}) >> (2 * FRAC_BITS);
    if (p > CAP) return CAP;
    return p[63:0];
  endfunction

  function automatic logic [VEL_W-1:0] along_normal(longint unsigned mag, longint n,
                                                   bit flip, longint base);
    longint v;
    v = longint'(mag);
    if (n < 0) v = -v;
    if (flip) v = -v;
    v = v + base;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[VEL_W-1:0];
  endfunction

  function automatic contact_res_t resolve_contact();
    contact_res_t    r;
    longint          avx, avy, bvx, bvy, nx, ny, dot;
    longint unsigned inva, invb, sum, ax, ay, cax, cay, cbx, cby, negv, e, jq, d, q;
    avx  = longint'(a_vel_x_i);
    avy  = longint'(a_vel_y_i);
    bvx  = longint'(b_vel_x_i);
    bvy  = longint'(b_vel_y_i);
    nx   = longint'(normal_x_i);
    ny   = longint'(normal_y_i);
    inva = a_inv_mass_i;
    invb = b_inv_mass_i;
    dot  = (bvx - avx) * nx + (bvy - avy) * ny;
    sum  = inva + invb;
    r.sep = dot > 0;
    r.imm = sum == 0;
    r.word[0] = avx[31:0];
    r.word[1] = avy[31:0];
    r.word[2] = bvx[31:0];
    r.word[3] = bvy[31:0];
    for (int i = 4; i < 8; i++) r.word[i] = '0;
    if (!r.imm) begin
      ax  = (nx < 0) ? -nx : nx;
      ay  = (ny < 0) ? -ny : ny;
      cax = inva * ax;
      cay = inva * ay;
      cbx = invb * ax;
      cby = invb * ay;
      if (!r.sep) begin
        negv = (unsigned'(-dot) + ONE - 1) >> FRAC_BITS;
        e    = (a_bounce_i > b_bounce_i) ? a_bounce_i : b_bounce_i;
        jq   = ((ONE + e) * negv) / sum;
        r.word[0] = along_normal(scale_mag(jq, cax), nx, 1'b1, avx);
        r.word[1] = along_normal(scale_mag(jq, cay), ny, 1'b1, avy);
        r.word[2] = along_normal(scale_mag(jq, cbx), nx, 1'b0, bvx);
        r.word[3] = along_normal(scale_mag(jq, cby), ny, 1'b0, bvy);
      end
      d = (depth_i > slop_q) ? depth_i - slop_q : 0;
      q = (d * pct_q) / sum;
      r.word[4] = along_normal(scale_mag(q, cax), nx, 1'b1, 0);
      r.word[5] = along_normal(scale_mag(q, cay), ny, 1'b1, 0);
      r.word[6] = along_normal(scale_mag(q, cbx), nx, 1'b0, 0);
      r.word[7] = along_normal(scale_mag(q, cby), ny, 1'b0, 0);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t want;
    contact_res_t got;
    if (!rst_ni) begin
      pct_q  <= PCT_RESET;
      slop_q <= SLOP_RESET;
      expected_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (start_i && !busy_i) expected_q.insert(expected_q.size(), resolve_contact());
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PCT: begin
            pct_q <= cfg_data_i[PCT_W-1:0];
          end
          CFG_SLOP: begin
            slop_q <= cfg_data_i[SLOP_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (done_i) begin
        got.word = result_i;
        got.sep  = separating_i;
        got.imm  = both_immovable_i;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("checker: result word with nothing expected: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              for (int i = 0; i < 8; i++)
                if (got.word[i] !== want.word[i])
                  $display("checker: word %0d expected %h actual %h", i, want.word[i],
                           got.word[i]);
              $display("checker: sep expected %b actual %b, imm expected %b actual %b",
                       want.sep, got.sep, want.imm, got.imm);
            end
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icr_pkg::*;

  logic                    clk, rst_n, start, busy, cfg_valid, cfg_ready, done, sep, imm;
  logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
  logic [INV_W-1:0]        inva, invb;
  logic [BNC_W-1:0]        ea, eb;
  logic signed [NRM_W-1:0] nx, ny;
  logic [DEP_W-1:0]        depth;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic [7:0][VEL_W-1:0]   result;
  int                      errors, pending;

  impulse_collision_response_2d_top u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .a_vel_x_i(avx), .a_vel_y_i(avy), .b_vel_x_i(bvx), .b_vel_y_i(bvy),
    .a_inv_mass_i(inva), .b_inv_mass_i(invb), .a_bounce_i(ea), .b_bounce_i(eb),
    .normal_x_i(nx), .normal_y_i(ny), .depth_i(depth),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .done_o(done),
    .a_new_vel_x_o(result[0]), .a_new_vel_y_o(result[1]),
    .b_new_vel_x_o(result[2]), .b_new_vel_y_o(result[3]),
    .a_shift_x_o(result[4]), .a_shift_y_o(result[5]),
    .b_shift_x_o(result[6]), .b_shift_y_o(result[7]),
    .separating_o(sep), .both_immovable_o(imm)
  );

  impulse_collision_response_2d_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .a_vel_x_i(avx), .a_vel_y_i(avy), .b_vel_x_i(bvx), .b_vel_y_i(bvy),
    .a_inv_mass_i(inva), .b_inv_mass_i(invb), .a_bounce_i(ea), .b_bounce_i(eb),
    .normal_x_i(nx), .normal_y_i(ny), .depth_i(depth),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .done_i(done), .result_i(result),
    .separating_i(sep), .both_immovable_i(imm), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  task automatic send_contact(input logic [31:0] a_x, a_y, b_x, b_y,
                              input logic [30:0] ia, ib, input logic [16:0] ba, bb,
                              input logic [17:0] n_x, n_y, input logic [30:0] dep);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    avx <= a_x; avy <= a_y; bvx <= b_x; bvy <= b_y;
    inva <= ia; invb <= ib; ea <= ba; eb <= bb;
    nx <= n_x; ny <= n_y; depth <= dep;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_W + 16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [17:0] pick_normal();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return '0;
      3: return 18'($urandom);
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic random_contact();
    logic [31:0] r[4];
    logic [17:0] n_x, n_y;
    if ($urandom_range(0, 3) == 0) begin
      send_contact($urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                   17'($urandom), 17'($urandom), 18'($urandom), 18'($urandom),
                   31'($urandom));
    end else begin
      foreach (r[i]) r[i] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      n_x = pick_normal();
      n_y = pick_normal();
      send_contact(r[0], r[1], r[2], r[3],
                   ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 32'h4_0000)),
                   ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 32'h4_0000)),
                   17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                   n_x, n_y, 31'($urandom_range(0, 32'h4_0000)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_idx = CFG_PCT;
    cfg_data = '0;
    {avx, avy, bvx, bvy, inva, invb, ea, eb, nx, ny, depth} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_contact(32'h10000, 0, 0, 0, 0, 0, 65536, 0, 65536, 0, 31'h20000);
    send_contact(32'h10000, 0, 0, 0, 31'h10000, 31'h10000, 0, 65536, 65536, 0, 31'h20000);
    send_contact(0, 0, 32'h10000, 0, 31'h10000, 31'h10000, 65536, 0, 65536, 0, 31'h20000);
    send_contact(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
                 31'h7FFFFFFF, 17'h1FFFF, 17'h1FFFF, 18'h20000, 18'h1FFFF, 31'h7FFFFFFF);
    send_contact(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 31'h1, 0,
                 65536, 0, 18'h20000, 18'h20000, 31'h7FFFFFFF);
    send_contact(32'h50000, 32'h50000, 0, 0, 0, 31'h7FFFFFFF, 0, 65536,
                 -18'sd65536, 0, 31'd6554);
    send_contact(32'h30000, 0, 0, 32'h30000, 31'h8000, 31'h18000, 32768, 16384,
                 46341, -18'sd46341, 31'd6555);
    send_contact(0, 32'h20000, 0, 0, 31'h10000, 0, 65536, 65536, 0, 65536, 31'h50000);
    send_contact(0, 0, 0, 0, 31'h10000, 31'h10000, 0, 0, 65536, 0, 31'h10000);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_PCT, 0);
          write_reg(CFG_SLOP, 0);
        end
        2: begin
          write_reg(CFG_PCT, 65536);
          write_reg(CFG_SLOP, 32'h7FFFFFFF);
        end
        3: begin
          write_reg(CFG_PCT, 32'h1FFFF);
          write_reg(CFG_SLOP, 1);
        end
        4: begin
          write_reg(CFG_PCT, $urandom);
          write_reg(CFG_SLOP, $urandom);
        end
        5: begin
          write_reg(CFG_PCT, 58982);
          write_reg(CFG_SLOP, 6554);
        end
        default: begin
        end
      endcase
      for (int i = 0; i < 270; i++) random_contact();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[impulse_collision_response_2d_top.f]
+incdir+sv
sv/icr_pkg.sv
sv/icr_front.sv
sv/icr_fifo.sv
sv/icr_div.sv
sv/icr_scale.sv
sv/impulse_collision_response_2d_top.sv
dv/impulse_collision_response_2d_checker.sv
dv/tb.sv
